@@ rtl/kseq_pkg.sv @@
// Package for the key sequence detector: sizes, reset values, register codes
// and the case folding helper. No dependencies.
package kseq_pkg;

    localparam int KSEQ_MAX_SEQ_CHARS = 16;
    localparam int KSEQ_MAX_DIGITS    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int KEY_W    = 8;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 5;
    localparam int DCNT_W   = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 32;

    localparam logic [POS_W-1:0]  RST_SEQ_LENGTH = 5'd1;
    localparam logic [TIME_W-1:0] RST_GAP_LIMIT  = 32'd70;

    localparam logic [KEY_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [KEY_W-1:0] CHAR_NINE = 8'h39;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEQ_LOW     = 3'd0,
        CFG_SEQ_HIGH    = 3'd1,
        CFG_SEQ_LENGTH  = 3'd2,
        CFG_DIGIT_COUNT = 3'd3,
        CFG_GAP_LIMIT   = 3'd4,
        CFG_ECHO_OFF    = 3'd5
    } t_cfg_reg;

    function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] c);
        logic [KEY_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

@@ rtl/key_sequence_detector_top.sv @@
// Key sequence detector top level: input register, one-pass match logic and
// an output register. Depends on kseq_pkg.
//
// The block takes one keystroke item per cycle while the output side is not
// stalled and returns exactly one result item for it, via the input and output
// registers. The key is held in the input register, then compared, case-folded,
// against the sequence character at the current match position while the gap
// since the previous key is checked with one 32-bit subtract and compare; the
// new match state and the result are registered in the same cycle, which sets
// the one-item-per-cycle rate. Configuration is written through a plain write
// port; the user must do so only while the block is idle (not enforced here).
module key_sequence_detector_top
    import kseq_pkg::*;
#(
    parameter int MAX_SEQ_CHARS = KSEQ_MAX_SEQ_CHARS,
    parameter int MAX_DIGITS    = KSEQ_MAX_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_W-1:0]       i_s_tdata,   // key_code[7:0], now_ticks[39:8]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata    // matched[0], digit_first[8:1],
                                               // digit_second[16:9], echo_valid[17],
                                               // echo_key[25:18], zero[31:26]
);

    localparam logic [POS_W-1:0]  LEN_MAX  = POS_W'(MAX_SEQ_CHARS);
    localparam logic [DCNT_W-1:0] NEED_MAX = (MAX_DIGITS > 3) ? 2'd3 : DCNT_W'(MAX_DIGITS);
    localparam int                D1_IDX   = (MAX_DIGITS > 1) ? 1 : 0;

    logic [CFG_DATA_W-1:0] r_seq_low;
    logic [CFG_DATA_W-1:0] r_seq_high;
    logic [POS_W-1:0]      r_seq_length;
    logic [DCNT_W-1:0]     r_digit_count;
    logic [TIME_W-1:0]     r_gap_limit;
    logic                  r_echo_off;

    logic                  r_s1_valid;
    logic [KEY_W-1:0]      r_s1_key;
    logic [TIME_W-1:0]     r_s1_now;

    logic [POS_W-1:0]      r_match_pos;
    logic [DCNT_W-1:0]     r_digits_taken;
    logic [TIME_W-1:0]     r_last_time;
    logic [KEY_W-1:0]      r_store [MAX_DIGITS];

    logic                  r_out_valid;
    logic                  r_matched;
    logic [KEY_W-1:0]      r_digit_first;
    logic [KEY_W-1:0]      r_digit_second;
    logic                  r_echo_valid;
    logic [KEY_W-1:0]      r_echo_key;

    logic [POS_W-1:0]      n_match_pos;
    logic [DCNT_W-1:0]     n_digits_taken;
    logic [TIME_W-1:0]     n_last_time;
    logic [KEY_W-1:0]      n_store [MAX_DIGITS];
    logic                  n_matched;
    logic [KEY_W-1:0]      n_digit_first;
    logic [KEY_W-1:0]      n_digit_second;
    logic                  n_echo_valid;

    logic                  w_adv_out;
    logic                  w_fire;
    logic                  w_accept;
    logic [POS_W-1:0]      w_len;
    logic [DCNT_W-1:0]     w_need;
    logic                  w_gap_clear;
    logic [POS_W-1:0]      w_pos0;
    logic [DCNT_W-1:0]     w_dt0;
    logic [2*CFG_DATA_W-1:0] w_seq;
    logic [KEY_W-1:0]      w_key_f;
    logic [KEY_W-1:0]      w_seq_cur;
    logic [KEY_W-1:0]      w_seq_first;
    logic                  w_abort;

    assign w_adv_out  = !r_out_valid || i_m_tready;
    assign w_fire     = r_s1_valid && w_adv_out;
    assign o_s_tready = !r_s1_valid || w_adv_out;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_low     <= '0;
            r_seq_high    <= '0;
            r_seq_length  <= RST_SEQ_LENGTH;
            r_digit_count <= '0;
            r_gap_limit   <= RST_GAP_LIMIT;
            r_echo_off    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEQ_LOW:     r_seq_low     <= i_cfg_data;
                CFG_SEQ_HIGH:    r_seq_high    <= i_cfg_data;
                CFG_SEQ_LENGTH:  r_seq_length  <= i_cfg_data[POS_W-1:0];
                CFG_DIGIT_COUNT: r_digit_count <= i_cfg_data[DCNT_W-1:0];
                CFG_GAP_LIMIT:   r_gap_limit   <= i_cfg_data[TIME_W-1:0];
                CFG_ECHO_OFF:    r_echo_off    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_key <= i_s_tdata[KEY_W-1:0];
            r_s1_now <= i_s_tdata[KEY_W +: TIME_W];
        end
    end

    always_comb begin
        w_len = r_seq_length;
        if (r_seq_length == '0) begin
            w_len = POS_W'(1);
        end else if (r_seq_length > LEN_MAX) begin
            w_len = LEN_MAX;
        end
        w_need = (r_digit_count > NEED_MAX) ? NEED_MAX : r_digit_count;
    end

    assign w_gap_clear = (r_last_time != '0) && ((r_s1_now - r_last_time) > r_gap_limit);
    assign w_pos0      = w_gap_clear ? '0 : r_match_pos;
    assign w_dt0       = w_gap_clear ? '0 : r_digits_taken;
    assign w_seq       = {r_seq_high, r_seq_low};
    assign w_key_f     = fold_case(r_s1_key);
    assign w_seq_cur   = fold_case(w_seq[w_pos0[3:0]*KEY_W +: KEY_W]);
    assign w_seq_first = fold_case(w_seq[KEY_W-1:0]);

    always_comb begin
        n_match_pos    = w_pos0;
        n_digits_taken = w_dt0;
        n_last_time    = r_s1_now;
        n_store        = r_store;
        n_matched      = 1'b0;
        n_echo_valid   = 1'b0;
        n_digit_first  = '0;
        n_digit_second = '0;
        w_abort        = 1'b0;
        if (w_pos0 < w_len) begin
            if (w_key_f == w_seq_cur) begin
                n_match_pos = w_pos0 + POS_W'(1);
            end else begin
                n_match_pos = (w_key_f == w_seq_first) ? POS_W'(1) : '0;
            end
            n_digits_taken = '0;
            n_echo_valid   = (n_match_pos > POS_W'(1)) && !r_echo_off;
        end else if (w_dt0 < w_need) begin
            if (r_s1_key < CHAR_ZERO || r_s1_key > CHAR_NINE) begin
                n_match_pos    = '0;
                n_digits_taken = '0;
                n_last_time    = '0;
                w_abort        = 1'b1;
            end else begin
                for (int i = 0; i < MAX_DIGITS; i++) begin
                    if (int'(w_dt0) == i) begin
                        n_store[i] = r_s1_key;
                    end
                end
                n_digits_taken = w_dt0 + DCNT_W'(1);
            end
        end
        if (!w_abort && n_match_pos >= w_len && n_digits_taken >= w_need) begin
            n_matched      = 1'b1;
            n_match_pos    = '0;
            n_digits_taken = '0;
            n_last_time    = '0;
            if (w_need > DCNT_W'(0)) begin
                n_digit_first = n_store[0];
            end
            if (w_need > DCNT_W'(1) && MAX_DIGITS > 1) begin
                n_digit_second = n_store[D1_IDX];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_pos    <= '0;
            r_digits_taken <= '0;
            r_last_time    <= '0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= '0;
            end
        end else if (w_fire) begin
            r_match_pos    <= n_match_pos;
            r_digits_taken <= n_digits_taken;
            r_last_time    <= n_last_time;
            r_store        <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_matched      <= n_matched;
            r_digit_first  <= n_digit_first;
            r_digit_second <= n_digit_second;
            r_echo_valid   <= n_echo_valid;
            r_echo_key     <= n_echo_valid ? r_s1_key : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_echo_key, r_echo_valid, r_digit_second, r_digit_first,
                         r_matched};

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_pos <= LEN_MAX)
        else $error("Match position beyond the longest sequence.");

    a_clear_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_matched) |=> (r_match_pos == '0 && r_digits_taken == '0 &&
                                   r_last_time == '0))
        else $error("Progress not cleared after a full match.");

    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_echo_valid) |-> (r_echo_key == '0))
        else $error("Echo key nonzero without echo.");

    a_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_matched) |-> (r_digit_first == '0 && r_digit_second == '0))
        else $error("Digits given without a match.");

endmodule

@@ bench/key_sequence_detector_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for key_sequence_detector_top: directed keystroke runs, then random
// sequences against a cycle-free predictor. Depends on kseq_pkg and the top level.
module key_sequence_detector_top_test;
    import kseq_pkg::*;

    typedef struct packed {
        logic             matched;
        logic [KEY_W-1:0] digit_first;
        logic [KEY_W-1:0] digit_second;
        logic             echo_valid;
        logic [KEY_W-1:0] echo_key;
    } t_key_report;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_W-1:0]       i_s_tdata   = '0;  // key_code[7:0], now_ticks[39:8]
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b1;
    logic [OUT_W-1:0]      o_m_tdata;         // matched[0], digit_first[8:1],
                                              // digit_second[16:9], echo_valid[17],
                                              // echo_key[25:18], zero[31:26]

    t_key_report       pending_reports[$];
    int                error_count = 0;
    int                keys_sent   = 0;
    bit                src_gaps    = 1'b1;
    bit                sink_stalls = 1'b1;
    logic [TIME_W-1:0] clock_ticks = '0;

    logic [63:0]       seq_low;
    logic [63:0]       seq_high;
    logic [POS_W-1:0]  seq_len_cfg  = RST_SEQ_LENGTH;
    logic [DCNT_W-1:0] digits_cfg   = '0;
    logic [TIME_W-1:0] gap_cfg      = RST_GAP_LIMIT;
    logic              echo_off_cfg = 1'b0;

    int                seq_pos     = 0;
    int                digits_held = 0;
    logic [TIME_W-1:0] prev_ticks  = '0;
    logic [KEY_W-1:0]  digit_buf[KSEQ_MAX_DIGITS];

    key_sequence_detector_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("key_sequence_detector_top verification failed");
        $finish;
    end

    initial begin
        seq_low  = '0;
        seq_high = '0;
        foreach (digit_buf[i]) digit_buf[i] = '0;
    end

    function automatic logic [KEY_W-1:0] upper_case(input logic [KEY_W-1:0] c);
        if (c >= "a" && c <= "z") begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic [KEY_W-1:0] seq_byte(input int i);
        int slot;
        slot = i & 15;
        if (slot < 8) begin
            return seq_low[8*slot +: 8];
        end
        return seq_high[8*(slot-8) +: 8];
    endfunction

    function automatic t_key_report detect_key(input logic [KEY_W-1:0] key,
                                               input logic [TIME_W-1:0] ticks);
        t_key_report      rep;
        int               len;
        int               need;
        logic [KEY_W-1:0] k;
        logic             aborted;
        rep = '0;
        aborted = 1'b0;
        len = (seq_len_cfg == 0) ? 1 :
              (seq_len_cfg > KSEQ_MAX_SEQ_CHARS) ? KSEQ_MAX_SEQ_CHARS : int'(seq_len_cfg);
        need = (digits_cfg > KSEQ_MAX_DIGITS) ? KSEQ_MAX_DIGITS : int'(digits_cfg);
        if (prev_ticks != 0 && (ticks - prev_ticks) > gap_cfg) begin
            seq_pos = 0;
            digits_held = 0;
        end
        prev_ticks = ticks;
        if (seq_pos < len) begin
            k = upper_case(key);
            if (k == upper_case(seq_byte(seq_pos))) begin
                seq_pos++;
            end else begin
                seq_pos = (k == upper_case(seq_byte(0))) ? 1 : 0;
            end
            digits_held = 0;
            if (seq_pos > 1 && !echo_off_cfg) begin
                rep.echo_valid = 1'b1;
                rep.echo_key = key;
            end
        end else if (digits_held < need) begin
            if (key < CHAR_ZERO || key > CHAR_NINE) begin
                aborted = 1'b1;
                seq_pos = 0;
                digits_held = 0;
                prev_ticks = '0;
            end else begin
                digit_buf[digits_held] = key;
                digits_held++;
            end
        end
        if (!aborted && seq_pos >= len && digits_held >= need) begin
            seq_pos = 0;
            digits_held = 0;
            prev_ticks = '0;
            rep.matched = 1'b1;
            if (need > 0) rep.digit_first = digit_buf[0];
            if (need > 1) rep.digit_second = digit_buf[1];
        end
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_key_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("result item %h arrived with nothing expected", o_m_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("matched", 8'(want.matched), 8'(o_m_tdata[0]));
                check_field("digit_first", want.digit_first, o_m_tdata[8:1]);
                check_field("digit_second", want.digit_second, o_m_tdata[16:9]);
                check_field("echo_valid", 8'(want.echo_valid), 8'(o_m_tdata[17]));
                check_field("echo_key", want.echo_key, o_m_tdata[25:18]);
                check_field("padding", 8'd0, 8'(o_m_tdata[31:26]));
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    task automatic send_key(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] delta);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        clock_ticks += delta;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {clock_ticks, key};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_reports.push_back(detect_key(key, clock_ticks));
        keys_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_key(s[i], 32'd1);
        end
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SEQ_LOW:     seq_low = value;
            CFG_SEQ_HIGH:    seq_high = value;
            CFG_SEQ_LENGTH:  seq_len_cfg = value[POS_W-1:0];
            CFG_DIGIT_COUNT: digits_cfg = value[DCNT_W-1:0];
            CFG_GAP_LIMIT:   gap_cfg = value[TIME_W-1:0];
            CFG_ECHO_OFF:    echo_off_cfg = value[0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            v[8*i +: 8] = s[i];
        end
        return v;
    endfunction

    function automatic logic [TIME_W-1:0] step_delta();
        logic [TIME_W-1:0] span;
        span = (gap_cfg < 32'd40) ? gap_cfg : 32'd40;
        case ($urandom_range(0, 15))
            0:       return gap_cfg;
            1:       return gap_cfg + 32'd1;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] rand_seq_byte();
        case ($urandom_range(0, 3))
            0:       return KEY_W'("A" + $urandom_range(0, 25));
            1:       return KEY_W'("a" + $urandom_range(0, 25));
            2:       return KEY_W'("0" + $urandom_range(0, 9));
            default: return KEY_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic randomize_config();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len;
        logic [63:0] gap;
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = rand_seq_byte();
            hi[8*i +: 8] = rand_seq_byte();
        end
        case ($urandom_range(0, 9))
            0: lo = '0;
            1: lo = '1;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: hi = '0;
            1: hi = '1;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0:       len = 64'd0;
            1:       len = 64'(KSEQ_MAX_SEQ_CHARS);
            2:       len = 64'($urandom_range(17, 31));
            3:       len = 64'($urandom_range(7, 15));
            default: len = 64'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0:       gap = 64'd0;
            1:       gap = 64'hFFFF_FFFF;
            2:       gap = 64'($urandom());
            default: gap = 64'($urandom_range(20, 300));
        endcase
        write_reg(CFG_SEQ_LOW, lo);
        write_reg(CFG_SEQ_HIGH, hi);
        write_reg(CFG_SEQ_LENGTH, len);
        write_reg(CFG_DIGIT_COUNT, 64'($urandom_range(0, 3)));
        write_reg(CFG_GAP_LIMIT, gap);
        write_reg(CFG_ECHO_OFF, 64'($urandom_range(0, 1)));
    endtask

    task automatic send_attempt();
        int               len;
        logic [KEY_W-1:0] c;
        len = (seq_len_cfg == 0) ? 1 :
              (seq_len_cfg > KSEQ_MAX_SEQ_CHARS) ? KSEQ_MAX_SEQ_CHARS : int'(seq_len_cfg);
        for (int i = 0; i < len; i++) begin
            c = seq_byte(i);
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
                c ^= 8'h20;
            end
            if ($urandom_range(0, 24) == 0) c = KEY_W'($urandom_range(0, 255));
            send_key(c, step_delta());
        end
        for (int j = 0; j < digits_cfg; j++) begin
            c = KEY_W'("0" + $urandom_range(0, 9));
            if ($urandom_range(0, 7) == 0) c = KEY_W'($urandom_range(0, 255));
            send_key(c, step_delta());
        end
    endtask

    task automatic test_reset_defaults();
        send_key(8'h00, 32'd1);
        send_key(8'hFF, 32'd1);
    endtask

    task automatic test_case_and_echo();
        wait_idle();
        write_reg(CFG_SEQ_LOW, pack_text("aBc"));
        write_reg(CFG_SEQ_LENGTH, 64'd3);
        write_reg(CFG_GAP_LIMIT, 64'hFFFF_FFFF);
        send_text("AbC");
        send_text("Aabc");
    endtask

    task automatic test_digit_capture();
        wait_idle();
        write_reg(CFG_DIGIT_COUNT, 64'd2);
        write_reg(CFG_ECHO_OFF, 64'd1);
        send_text("abc42");
        send_text("aBcx");
    endtask

    task automatic test_gap_and_zero_stamp();
        wait_idle();
        write_reg(CFG_DIGIT_COUNT, 64'd0);
        write_reg(CFG_ECHO_OFF, 64'd0);
        write_reg(CFG_GAP_LIMIT, 64'd5);
        clock_ticks = 32'hFFFF_FFFC;
        send_key("a", 32'd0);
        send_key("b", 32'd5);
        send_key("c", 32'd6);
        clock_ticks = '0;
        send_key("a", 32'd0);
        send_key("b", 32'd1000);
        send_key("c", 32'd1);
    endtask

    task automatic test_length_shrink();
        wait_idle();
        write_reg(CFG_SEQ_LOW, pack_text("abcdefgh"));
        write_reg(CFG_SEQ_HIGH, pack_text("ijklmnop"));
        write_reg(CFG_SEQ_LENGTH, 64'(KSEQ_MAX_SEQ_CHARS));
        send_text("abcd");
        wait_idle();
        write_reg(CFG_SEQ_LENGTH, 64'd2);
        send_key("z", 32'd1);
    endtask

    task automatic test_random_traffic();
        int first;
        int round_start;
        int round_len;
        first = keys_sent;
        while (keys_sent - first < 1000) begin
            if (keys_sent - first > 850) begin
                src_gaps = 1'b0;
                sink_stalls = 1'b0;
            end else begin
                src_gaps = ($urandom_range(0, 2) != 0);
                sink_stalls = ($urandom_range(0, 2) != 0);
            end
            wait_idle();
            randomize_config();
            round_len = $urandom_range(20, 60);
            round_start = keys_sent;
            while (keys_sent - round_start < round_len) begin
                case ($urandom_range(0, 9))
                    0: send_key(KEY_W'($urandom_range(0, 255)), step_delta());
                    1: begin
                        case ($urandom_range(0, 2))
                            0:       clock_ticks = $urandom();
                            1:       clock_ticks = '0;
                            default: clock_ticks = 32'hFFFF_FFFF - $urandom_range(0, 40);
                        endcase
                        send_key(seq_byte(0), 32'd0);
                    end
                    default: send_attempt();
                endcase
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_case_and_echo();
        test_digit_capture();
        test_gap_and_zero_stamp();
        test_length_shrink();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("key_sequence_detector_top verification clean");
        end else begin
            $display("key_sequence_detector_top verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kseq_pkg.sv
rtl/key_sequence_detector_top.sv
bench/key_sequence_detector_top_test.sv
